// ===== rtl/rrts_pkg.sv =====
package rrts_pkg;

   localparam int NUM_TASKS           = 16;
   localparam int SLOT_W              = $clog2(NUM_TASKS);
   localparam int MIN_TASKS_TO_SWITCH = 2;
   localparam int COUNT_W             = 5;
   localparam int COUNT_MAX           = 31;
   localparam int TASK_INDEX_W        = 4;
   localparam int IDX_EXT_W           = (SLOT_W > TASK_INDEX_W) ? SLOT_W : TASK_INDEX_W;

   typedef enum logic [2:0] {
      OP_TICK    = 3'd0,
      OP_CREATE  = 3'd1,
      OP_BLOCK   = 3'd2,
      OP_UNBLOCK = 3'd3,
      OP_EXIT    = 3'd4,
      OP_START   = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      ST_UNUSED  = 3'd0,
      ST_READY   = 3'd1,
      ST_RUNNING = 3'd2,
      ST_BLOCKED = 3'd3,
      ST_DEAD    = 3'd4
   } slot_state_type;

   typedef struct packed {
      logic load;
      logic commit;
   } sched_cmd_type;

   typedef struct packed {
      logic              found;
      logic [SLOT_W-1:0] idx;
   } pick_type;

   // Lowest set bit, isolated and then encoded.
   function automatic logic [SLOT_W-1:0] first_set(input logic [NUM_TASKS-1:0] v);
      logic [NUM_TASKS-1:0] low;
      logic [SLOT_W-1:0]    idx;
      low = v & (~v + NUM_TASKS'(1));
      idx = '0;
      for (int i = 0; i < NUM_TASKS; i++) begin
         if (low[i]) begin
            idx = idx | SLOT_W'(i);
         end
      end
      return idx;
   endfunction

   // Round-robin pick: first candidate at or above the start position, else wrap.
   function automatic pick_type rr_pick(input logic [NUM_TASKS-1:0] v,
                                        input logic [NUM_TASKS-1:0] hi);
      pick_type p;
      p.found = |v;
      if (|(v & hi)) begin
         p.idx = first_set(v & hi);
      end else begin
         p.idx = first_set(v);
      end
      return p;
   endfunction

endpackage

// ===== rtl/rrts_ctrl.sv =====
module rrts_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rrts_pkg::sched_cmd_type cmd
);
   import rrts_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in   = state_ff;
      cmd.load   = 1'b0;
      cmd.commit = 1'b0;
      req_stall  = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            // The table update and the result load happen together, so a
            // word waits here until the output register can take its result.
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.commit || (rsp_valid_ff && rsp_stall);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !(rsp_valid_ff && rsp_stall))
      else $error("result overwritten while stalled");
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_EXEC))
      else $error("accepted word did not enter execution");
   a_commit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("committed result not presented");
   a_load_commit_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.load && cmd.commit))
      else $error("load and commit in the same cycle");
`endif

endmodule

// ===== rtl/rrts_datapath.sv =====
module rrts_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  rrts_pkg::sched_cmd_type cmd,
   input  logic [2:0]              req_operation,
   input  logic                    req_is_idle,
   input  logic [2:0]              req_wait_reason,
   input  logic [15:0]             req_wait_data,
   output logic                    rsp_ok,
   output logic [3:0]              rsp_task_index,
   output logic                    rsp_task_valid,
   output logic                    rsp_switched
);
   import rrts_pkg::*;

   // Captured request word.
   op_type      op_ff;
   logic        is_idle_ff;
   logic [2:0]  reason_req_ff;
   logic [15:0] data_req_ff;

   // Task table and scheduler state.
   slot_state_type     state_ff  [NUM_TASKS];
   slot_state_type     state_in  [NUM_TASKS];
   logic [2:0]         reason_ff [NUM_TASKS];
   logic [2:0]         reason_in [NUM_TASKS];
   logic [15:0]        wdata_ff  [NUM_TASKS];
   logic [15:0]        wdata_in  [NUM_TASKS];
   logic [NUM_TASKS-1:0] idle_ff, idle_in;
   logic [SLOT_W-1:0]  cur_ff, cur_in;
   logic               present_ff, present_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               running_ff, running_in;

   // Result register.
   logic              ok_ff, valid_ff, switched_ff;
   logic [3:0]        index_ff;

   slot_state_type       adj [NUM_TASKS];
   logic [NUM_TASKS-1:0] rdy, rdy_busy, free, ready_now, match, hi;
   logic [SLOT_W-1:0]    start, cand, new_slot;
   logic                 take, ok, created, switched;
   pick_type             pick_n, pick_a;
   logic [IDX_EXT_W-1:0] idx_ext;

   always_comb begin
      state_in   = state_ff;
      reason_in  = reason_ff;
      wdata_in   = wdata_ff;
      idle_in    = idle_ff;
      cur_in     = cur_ff;
      present_in = present_ff;
      count_in   = count_ff;
      running_in = running_ff;
      ok         = 1'b0;
      created    = 1'b0;
      switched   = 1'b0;
      take       = 1'b0;
      cand       = '0;
      new_slot   = first_set(free);

      // Table as a tick sees it once the current task has been retired.
      adj = state_ff;
      if (present_ff) begin
         if (adj[cur_ff] == ST_RUNNING) begin
            adj[cur_ff] = ST_READY;
         end
         if (adj[cur_ff] == ST_DEAD) begin
            adj[cur_ff] = ST_UNUSED;
         end
      end
      if (!present_ff) begin
         start = '0;
      end else if (cur_ff == SLOT_W'(NUM_TASKS - 1)) begin
         start = '0;
      end else begin
         start = cur_ff + SLOT_W'(1);
      end

      for (int i = 0; i < NUM_TASKS; i++) begin
         rdy[i]       = (adj[i] == ST_READY);
         rdy_busy[i]  = rdy[i] && !idle_ff[i];
         free[i]      = (state_ff[i] == ST_UNUSED);
         ready_now[i] = (state_ff[i] == ST_READY);
         match[i]     = (state_ff[i] == ST_BLOCKED) && (reason_ff[i] == reason_req_ff)
                        && (wdata_ff[i] == data_req_ff);
         hi[i]        = (SLOT_W'(i) >= start);
      end
      new_slot = first_set(free);
      pick_n   = rr_pick(rdy_busy, hi);
      pick_a   = rr_pick(rdy, hi);

      case (op_ff)
         OP_TICK: begin
            if (running_ff && (count_ff >= COUNT_W'(MIN_TASKS_TO_SWITCH))) begin
               ok       = 1'b1;
               state_in = adj;
               if (pick_n.found) begin
                  take = 1'b1;
                  cand = pick_n.idx;
               end else if (present_ff && (adj[cur_ff] == ST_READY)) begin
                  // No non-idle task is ready: keep the current task running.
                  state_in[cur_ff] = ST_RUNNING;
               end else if (pick_a.found) begin
                  take = 1'b1;
                  cand = pick_a.idx;
               end
               if (take) begin
                  cur_in         = cand;
                  present_in     = 1'b1;
                  state_in[cand] = ST_RUNNING;
                  switched       = 1'b1;
               end
            end
         end
         OP_CREATE: begin
            if (|free) begin
               state_in[new_slot]  = ST_READY;
               idle_in[new_slot]   = is_idle_ff;
               reason_in[new_slot] = '0;
               if (count_ff != COUNT_W'(COUNT_MAX)) begin
                  count_in = count_ff + COUNT_W'(1);
               end
               created = 1'b1;
               ok      = 1'b1;
            end
         end
         OP_BLOCK: begin
            if (present_ff) begin
               reason_in[cur_ff] = reason_req_ff;
               wdata_in[cur_ff]  = data_req_ff;
               state_in[cur_ff]  = ST_BLOCKED;
               ok                = 1'b1;
            end
         end
         OP_UNBLOCK: begin
            for (int i = 0; i < NUM_TASKS; i++) begin
               if (match[i]) begin
                  state_in[i]  = ST_READY;
                  reason_in[i] = '0;
               end
            end
            ok = |match;
         end
         OP_EXIT: begin
            if (present_ff) begin
               state_in[cur_ff] = ST_DEAD;
               if (count_ff != '0) begin
                  count_in = count_ff - COUNT_W'(1);
               end
               ok = 1'b1;
            end
         end
         OP_START: begin
            if (count_ff != '0) begin
               running_in = 1'b1;
               if (|ready_now) begin
                  cur_in                       = first_set(ready_now);
                  present_in                   = 1'b1;
                  state_in[first_set(ready_now)] = ST_RUNNING;
               end
               ok = 1'b1;
            end
         end
         default: begin
            ok = 1'b0;
         end
      endcase

      if (created) begin
         idx_ext = IDX_EXT_W'(new_slot);
      end else if (present_in) begin
         idx_ext = IDX_EXT_W'(cur_in);
      end else begin
         idx_ext = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff         <= op_type'(req_operation);
         is_idle_ff    <= req_is_idle;
         reason_req_ff <= req_wait_reason;
         data_req_ff   <= req_wait_data;
      end
      if (cmd.commit) begin
         ok_ff       <= ok;
         index_ff    <= idx_ext[3:0];
         valid_ff    <= created || present_in;
         switched_ff <= switched;
         wdata_ff    <= wdata_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_TASKS; i++) begin
            state_ff[i]  <= ST_UNUSED;
            reason_ff[i] <= '0;
         end
         idle_ff    <= '0;
         cur_ff     <= '0;
         present_ff <= 1'b0;
         count_ff   <= '0;
         running_ff <= 1'b0;
      end else if (cmd.commit) begin
         state_ff   <= state_in;
         reason_ff  <= reason_in;
         idle_ff    <= idle_in;
         cur_ff     <= cur_in;
         present_ff <= present_in;
         count_ff   <= count_in;
         running_ff <= running_in;
      end
   end

   assign rsp_ok         = ok_ff;
   assign rsp_task_index = index_ff;
   assign rsp_task_valid = valid_ff;
   assign rsp_switched   = switched_ff;

endmodule

// ===== rtl/round_robin_task_scheduler_unit.sv =====
// Round-robin task scheduler over a table of task slots. Every request word
// goes through two steps: a capture step, and an execute step in which the
// whole table is evaluated and updated, with the response loaded into an
// output register. The input is stalled during the execute step. It stays
// stalled for as long as the previous response is still held by the receiver,
// because a finished word's response cannot be loaded until the output
// register is free. A new word is taken in the cycle after its predecessor has
// been executed, even while that response still waits to be taken. The task
// pick on a tick is a parallel rotating priority search over all slots done in
// the execute step, so no new word is taken while one is executing.
module round_robin_task_scheduler_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_operation,
   input  logic        req_is_idle,
   input  logic [2:0]  req_wait_reason,
   input  logic [15:0] req_wait_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_ok,
   output logic [3:0]  rsp_task_index,
   output logic        rsp_task_valid,
   output logic        rsp_switched
);
   import rrts_pkg::*;

   sched_cmd_type cmd;

   rrts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   rrts_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_operation   (req_operation),
      .req_is_idle     (req_is_idle),
      .req_wait_reason (req_wait_reason),
      .req_wait_data   (req_wait_data),
      .rsp_ok          (rsp_ok),
      .rsp_task_index  (rsp_task_index),
      .rsp_task_valid  (rsp_task_valid),
      .rsp_switched    (rsp_switched)
   );

endmodule
